### src/gtg_pkg.sv
`default_nettype none
package gtg_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ROOT_STEPS = 32;

	localparam int CW = 32;
	localparam int HW = 16;
	localparam int DW = 33;
	localparam int XW = 36;
	localparam int ZW = 35;
	localparam int EW = 36;
	localparam int RW = 64;
	localparam int PW = 53;
	localparam int TW = 24;
	localparam int GW = 16;
	localparam int SW = 32;
	localparam int IDXW = 8;
	localparam int DATAW = 32;
	localparam int ATAN_W = 30;
	localparam int HD_SHIFT = 18;
	localparam int TURN_SHIFT = 26;

	localparam logic signed [EW-1:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [EW-1:0] TWO_PI_Q30 = 36'sd6746518852;
	localparam logic signed [ZW-1:0] PI_Z = 35'sd3373259426;

	localparam logic signed [PW-1:0] ROUND_HALF = 53'sd33554432;
	localparam logic signed [PW-1:0] TURN_MAX = 53'sd8388607;
	localparam logic signed [PW-1:0] TURN_MIN = -53'sd8388608;

	localparam logic [IDXW-1:0] REG_GAIN = 8'd0;
	localparam logic [IDXW-1:0] REG_SPEED_LIMIT = 8'd1;

	localparam logic [GW-1:0] GAIN_RST = 16'd256;
	localparam logic [SW-1:0] SPEED_RST = 32'd65536;

	localparam logic [ATAN_W-1:0] ATAN_LOW [11] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
		30'd67021687, 30'd33543516, 30'd16775851, 30'd8388437,
		30'd4194283, 30'd2097149, 30'd1048576
	};

	function automatic logic [ATAN_W-1:0] atan_entry(input int i);
		logic [ATAN_W-1:0] r;
		r = '0;
		if (i < 11) begin
			r = ATAN_LOW[i[3:0]];
		end else if (i <= 30) begin
			r = ATAN_W'(1) << (30 - i);
		end
		return r;
	endfunction

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic [RW-1:0]        rem;
		logic [RW-1:0]        root;
		logic                 carry;
		logic                 zero;
		logic signed [HW-1:0] hd;
	} iter_t;

endpackage
`default_nettype wire

### src/gtg_in_if.sv
`default_nettype none
interface gtg_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [gtg_pkg::CW-1:0]      cur_x;
	logic signed [gtg_pkg::CW-1:0]      cur_y;
	logic signed [gtg_pkg::HW-1:0]      cur_heading;
	logic signed [gtg_pkg::CW-1:0]      goal_x;
	logic signed [gtg_pkg::CW-1:0]      goal_y;

	modport source (
		output valid, cur_x, cur_y, cur_heading, goal_x, goal_y,
		input  ready
	);
	modport sink (
		input  valid, cur_x, cur_y, cur_heading, goal_x, goal_y,
		output ready
	);
endinterface
`default_nettype wire

### src/gtg_out_if.sv
`default_nettype none
interface gtg_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [gtg_pkg::TW-1:0]      turn_rate;
	logic [gtg_pkg::SW-1:0]             forward_speed;

	modport source (
		output valid, turn_rate, forward_speed,
		input  ready
	);
	modport sink (
		input  valid, turn_rate, forward_speed,
		output ready
	);
endinterface
`default_nettype wire

### src/gtg_cfg_if.sv
`default_nettype none
interface gtg_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [gtg_pkg::IDXW-1:0]           index;
	logic [gtg_pkg::DATAW-1:0]          data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface
`default_nettype wire

### src/gtg_iter_stage.sv
`default_nettype none
module gtg_iter_stage #(
	parameter int STAGE = 0,
	parameter bit ROTATE = 1'b1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic           valid_in,
	input  wire gtg_pkg::iter_t iter_in,
	output logic                valid_s1,
	output gtg_pkg::iter_t      iter_s1
);

	localparam logic [gtg_pkg::RW-1:0] ROOT_BIT =
		gtg_pkg::RW'(1) << (2 * (gtg_pkg::ROOT_STEPS - 1 - STAGE));
	localparam logic signed [gtg_pkg::ZW-1:0] ATAN_Z =
		$signed(gtg_pkg::ZW'(gtg_pkg::atan_entry(STAGE)));

	logic signed [gtg_pkg::XW-1:0] xs;
	logic signed [gtg_pkg::XW-1:0] ys;
	logic [gtg_pkg::RW-1:0]        trial;
	gtg_pkg::iter_t                nxt;

	always_comb begin
		nxt = iter_in;
		xs = iter_in.x >>> STAGE;
		ys = iter_in.y >>> STAGE;
		if (ROTATE) begin
			if (iter_in.y > 0) begin
				nxt.x = iter_in.x + ys;
				nxt.y = iter_in.y - xs;
				nxt.z = iter_in.z + ATAN_Z;
			end else begin
				nxt.x = iter_in.x - ys;
				nxt.y = iter_in.y + xs;
				nxt.z = iter_in.z - ATAN_Z;
			end
		end
		trial = iter_in.root + ROOT_BIT;
		if (iter_in.rem >= trial) begin
			nxt.rem = iter_in.rem - trial;
			nxt.root = (iter_in.root >> 1) + ROOT_BIT;
		end else begin
			nxt.root = iter_in.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			iter_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

### src/go_to_goal_velocity_controller.sv
// An accepted pose passes s1-s4, the root/CORDIC stages and s5-s8 to cmd.
// Throughput: one transaction per cycle; the 32 square-root steps, which run
// alongside the CORDIC stages, set the depth. A stall on cmd holds every stage.
// Reset clears all valid bits and loads gain = 1.0 and speed_limit = 1.0;
// there is no clearing pass, and cfg is always ready.
`default_nettype none
module go_to_goal_velocity_controller #(
	parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gtg_in_if.sink     pose,
	gtg_out_if.source  cmd,
	gtg_cfg_if.sink    cfg
);

	localparam int N = gtg_pkg::ROOT_STEPS;

	logic                              adv;
	logic [gtg_pkg::GW-1:0]            gain_q;
	logic [gtg_pkg::SW-1:0]            speed_limit_q;

	logic                              valid_s1, valid_s2, valid_s3, valid_s4;
	logic                              valid_s5, valid_s6, valid_s7, valid_s8;

	logic signed [gtg_pkg::DW-1:0]     dx_s1, dy_s1;
	logic signed [gtg_pkg::HW-1:0]     hd_s1, hd_s2, hd_s3;

	logic [gtg_pkg::CW-1:0]            ax_s2, ay_s2;
	logic signed [gtg_pkg::XW-1:0]     x_s2, y_s2, x_s3, y_s3;
	logic signed [gtg_pkg::ZW-1:0]     z_s2, z_s3;
	logic                              zero_s2, zero_s3;

	logic [gtg_pkg::RW-1:0]            sx2_s3, sy2_s3;
	logic [gtg_pkg::RW:0]              sum_c;
	gtg_pkg::iter_t                    iter_s4;

	logic                              iter_v [0:N];
	gtg_pkg::iter_t                    iter_d [0:N];

	logic signed [gtg_pkg::EW-1:0]     zb_c;
	logic signed [gtg_pkg::EW-1:0]     err_s5, werr_s6;
	logic [gtg_pkg::SW-1:0]            speed_s5, speed_s6, speed_s7, speed_s8;
	logic signed [gtg_pkg::PW-1:0]     prod_c, prod_s7;
	logic signed [gtg_pkg::PW-1:0]     rnd_c, trunc_c;
	logic signed [gtg_pkg::TW-1:0]     turn_c, turn_s8;

	assign adv = !valid_s8 || cmd.ready;
	assign pose.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= gtg_pkg::GAIN_RST;
			speed_limit_q <= gtg_pkg::SPEED_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				gtg_pkg::REG_GAIN: gain_q <= cfg.data[gtg_pkg::GW-1:0];
				gtg_pkg::REG_SPEED_LIMIT: speed_limit_q <= cfg.data[gtg_pkg::SW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pose.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= iter_v[N];
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	// front end: differences, pre-rotation, squares, sum
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= gtg_pkg::DW'(pose.goal_x) - gtg_pkg::DW'(pose.cur_x);
			dy_s1 <= gtg_pkg::DW'(pose.goal_y) - gtg_pkg::DW'(pose.cur_y);
			hd_s1 <= pose.cur_heading;

			ax_s2 <= gtg_pkg::CW'(dx_s1[gtg_pkg::DW-1] ? -dx_s1 : dx_s1);
			ay_s2 <= gtg_pkg::CW'(dy_s1[gtg_pkg::DW-1] ? -dy_s1 : dy_s1);
			if (dx_s1[gtg_pkg::DW-1]) begin
				x_s2 <= -gtg_pkg::XW'(dx_s1);
				y_s2 <= -gtg_pkg::XW'(dy_s1);
				z_s2 <= dy_s1[gtg_pkg::DW-1] ? -gtg_pkg::PI_Z : gtg_pkg::PI_Z;
			end else begin
				x_s2 <= gtg_pkg::XW'(dx_s1);
				y_s2 <= gtg_pkg::XW'(dy_s1);
				z_s2 <= '0;
			end
			zero_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
			hd_s2 <= hd_s1;

			sx2_s3 <= gtg_pkg::RW'(ax_s2) * gtg_pkg::RW'(ax_s2);
			sy2_s3 <= gtg_pkg::RW'(ay_s2) * gtg_pkg::RW'(ay_s2);
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			z_s3 <= z_s2;
			zero_s3 <= zero_s2;
			hd_s3 <= hd_s2;

			iter_s4.x <= x_s3;
			iter_s4.y <= y_s3;
			iter_s4.z <= z_s3;
			iter_s4.rem <= sum_c[gtg_pkg::RW-1:0];
			iter_s4.root <= '0;
			iter_s4.carry <= sum_c[gtg_pkg::RW];
			iter_s4.zero <= zero_s3;
			iter_s4.hd <= hd_s3;
		end
	end

	assign sum_c = (gtg_pkg::RW + 1)'(sx2_s3) + (gtg_pkg::RW + 1)'(sy2_s3);

	assign iter_v[0] = valid_s4;
	assign iter_d[0] = iter_s4;

	for (genvar k = 0; k < N; k++) begin : g_iter
		gtg_iter_stage #(
			.STAGE  (k),
			.ROTATE (k < CORDIC_STAGES)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.valid_in (iter_v[k]),
			.iter_in  (iter_d[k]),
			.valid_s1 (iter_v[k+1]),
			.iter_s1  (iter_d[k+1])
		);
	end

	// back end: heading error, speed clamp, wrap, gain, round and saturate
	assign zb_c = iter_d[N].zero ? '0 : gtg_pkg::EW'(iter_d[N].z);
	assign prod_c = werr_s6 * $signed({1'b0, gain_q});
	assign rnd_c = prod_s7 + gtg_pkg::ROUND_HALF;
	assign trunc_c = rnd_c >>> gtg_pkg::TURN_SHIFT;

	always_comb begin
		if (trunc_c > gtg_pkg::TURN_MAX) begin
			turn_c = gtg_pkg::TW'(gtg_pkg::TURN_MAX);
		end else if (trunc_c < gtg_pkg::TURN_MIN) begin
			turn_c = gtg_pkg::TW'(gtg_pkg::TURN_MIN);
		end else begin
			turn_c = gtg_pkg::TW'(trunc_c);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s5 <= zb_c - (gtg_pkg::EW'(iter_d[N].hd) <<< gtg_pkg::HD_SHIFT);
			if (iter_d[N].carry) begin
				speed_s5 <= speed_limit_q;
			end else if (iter_d[N].root < gtg_pkg::RW'(speed_limit_q)) begin
				speed_s5 <= iter_d[N].root[gtg_pkg::SW-1:0];
			end else begin
				speed_s5 <= speed_limit_q;
			end

			if (err_s5 > gtg_pkg::PI_Q30) begin
				werr_s6 <= err_s5 - gtg_pkg::TWO_PI_Q30;
			end else if (err_s5 < -gtg_pkg::PI_Q30) begin
				werr_s6 <= err_s5 + gtg_pkg::TWO_PI_Q30;
			end else begin
				werr_s6 <= err_s5;
			end
			speed_s6 <= speed_s5;

			prod_s7 <= prod_c;
			speed_s7 <= speed_s6;

			turn_s8 <= turn_c;
			speed_s8 <= speed_s7;
		end
	end

	assign cmd.valid = valid_s8;
	assign cmd.turn_rate = turn_s8;
	assign cmd.forward_speed = speed_s8;

	a_zero_delta: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid && pose.ready && pose.cur_x == pose.goal_x &&
		pose.cur_y == pose.goal_y |=> valid_s1 && dx_s1 == '0 && dy_s1 == '0)
		else $error("zero offset lost in difference stage");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && !cmd.ready |-> !pose.ready)
		else $error("pose accepted while output stalled");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd.valid) |-> $past(valid_s7))
		else $error("command appeared without a product stage entry");

endmodule
`default_nettype wire

### test/tb_go_to_goal_velocity_controller.sv
`timescale 1ns / 100ps
module tb_go_to_goal_velocity_controller;

	localparam int STAGES = gtg_pkg::CORDIC_STAGES_DEF;
	localparam int LATENCY = 40;
	localparam int CONFIG_PHASES = 8;
	localparam int POSES_PER_PHASE = 125;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint TWO_PI_Q30 = 64'sd6746518852;
	localparam longint TURN_HI = 64'sd8388607;
	localparam longint TURN_LO = -64'sd8388608;
	localparam logic [gtg_pkg::IDXW-1:0] REG_SPARE = 8'd2;
	localparam logic [gtg_pkg::IDXW-1:0] REG_LAST = 8'hFF;
	localparam int C_MAX = 32'sh7FFF_FFFF;
	localparam int C_MIN = 32'sh8000_0000;
	localparam longint ARCTAN_Q30 [11] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576
	};

	typedef struct packed {
		logic signed [gtg_pkg::CW-1:0] cur_x;
		logic signed [gtg_pkg::CW-1:0] cur_y;
		logic signed [gtg_pkg::HW-1:0] cur_heading;
		logic signed [gtg_pkg::CW-1:0] goal_x;
		logic signed [gtg_pkg::CW-1:0] goal_y;
	} pose_t;

	typedef struct packed {
		logic signed [gtg_pkg::TW-1:0] turn_rate;
		logic [gtg_pkg::SW-1:0]        forward_speed;
	} cmd_t;

	typedef struct {
		pose_t pose;
		bit    fixed_turn;
		bit    fixed_speed;
		cmd_t  cmd;
	} goal_row_t;

	logic clk;
	logic arst_n;

	gtg_in_if  pose_if ();
	gtg_out_if cmd_if ();
	gtg_cfg_if cfg_if ();

	logic [gtg_pkg::GW-1:0] gain_q88;
	logic [gtg_pkg::SW-1:0] limit_q16;
	cmd_t cmd_expected [$];
	int mismatch_count;
	int cmd_count;
	int stall_left;
	int settings_count;
	bit idle_on;

	go_to_goal_velocity_controller i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pose   (pose_if),
		.cmd    (cmd_if),
		.cfg    (cfg_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint arctan_q30(int i);
		if (i < 11) return ARCTAN_Q30[i];
		if (i <= 30) return longint'(1) << (30 - i);
		return 0;
	endfunction

	function automatic longint bearing_q30(longint dx, longint dy);
		longint x, y, z, xs, ys;
		int i;
		x = dx;
		y = dy;
		z = 0;
		if (dx == 0 && dy == 0) return 0;
		if (x < 0) begin
			z = (dy >= 0) ? PI_Q30 : -PI_Q30;
			x = -x;
			y = -y;
		end
		for (i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + arctan_q30(i);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - arctan_q30(i);
			end
		end
		return z;
	endfunction

	function automatic logic [31:0] floor_sqrt(logic [63:0] v);
		logic [63:0] rem, root, probe;
		rem = v;
		root = '0;
		probe = 64'h4000_0000_0000_0000;
		while (probe > v) probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root[31:0];
	endfunction

	function automatic cmd_t predict_cmd(pose_t p, logic [15:0] g, logic [31:0] lim);
		longint dx, dy, err, prod, turn;
		logic [63:0] ax, ay, sq_x, sq_y;
		logic [64:0] sum;
		logic [31:0] reach;
		cmd_t c;
		dx = longint'($signed(p.goal_x)) - longint'($signed(p.cur_x));
		dy = longint'($signed(p.goal_y)) - longint'($signed(p.cur_y));
		err = bearing_q30(dx, dy) - longint'($signed(p.cur_heading)) * 262144;
		if (err > PI_Q30) err = err - TWO_PI_Q30;
		if (err < -PI_Q30) err = err + TWO_PI_Q30;
		prod = err * longint'({48'd0, g});
		turn = (prod + (longint'(1) << 25)) >>> 26;
		if (turn > TURN_HI) turn = TURN_HI;
		if (turn < TURN_LO) turn = TURN_LO;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		sq_x = ax * ax;
		sq_y = ay * ay;
		sum = {1'b0, sq_x} + {1'b0, sq_y};
		if (sum[64]) begin
			c.forward_speed = lim;
		end else begin
			reach = floor_sqrt(sum[63:0]);
			c.forward_speed = (reach < lim) ? reach : lim;
		end
		c.turn_rate = turn[23:0];
		return c;
	endfunction

	function automatic logic signed [31:0] rand_offset();
		int unsigned sh;
		sh = $urandom_range(0, 31);
		return $signed($urandom) >>> sh;
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		logic signed [31:0] dx, dy;
		int unsigned kind;
		kind = $urandom_range(0, 9);
		p.cur_x = $urandom;
		p.cur_y = $urandom;
		p.cur_heading = 16'($urandom);
		dx = rand_offset();
		dy = rand_offset();
		case (kind)
			0: begin
				dx = $urandom;
				dy = $urandom;
			end
			5: begin
				dx = 0;
				dy = 0;
			end
			6: dx = 0;
			7: dy = 0;
			8: p.cur_heading = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			9: begin
				p.cur_x = $signed($urandom) >>> 11;
				p.cur_y = $signed($urandom) >>> 11;
			end
			default: ;
		endcase
		p.goal_x = p.cur_x + dx;
		p.goal_y = p.cur_y + dy;
		return p;
	endfunction

	function automatic goal_row_t goal_row(int cx, int cy, int hd, int gx, int gy,
			bit ft, int turn, bit fs, int unsigned speed);
		goal_row_t r;
		r.pose.cur_x = cx;
		r.pose.cur_y = cy;
		r.pose.cur_heading = 16'(hd);
		r.pose.goal_x = gx;
		r.pose.goal_y = gy;
		r.fixed_turn = ft;
		r.fixed_speed = fs;
		r.cmd.turn_rate = 24'(turn);
		r.cmd.forward_speed = speed;
		return r;
	endfunction

	task automatic send_pose(pose_t p, cmd_t want);
		pose_if.valid <= 1'b1;
		pose_if.cur_x <= p.cur_x;
		pose_if.cur_y <= p.cur_y;
		pose_if.cur_heading <= p.cur_heading;
		pose_if.goal_x <= p.goal_x;
		pose_if.goal_y <= p.goal_y;
		@(posedge clk);
		while (!pose_if.ready) @(posedge clk);
		cmd_expected = {cmd_expected, want};
		if (idle_on && $urandom_range(0, 7) == 0) begin
			pose_if.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [gtg_pkg::IDXW-1:0] idx, logic [31:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		case (idx)
			gtg_pkg::REG_GAIN: gain_q88 = value[15:0];
			gtg_pkg::REG_SPEED_LIMIT: limit_q16 = value;
			default: ;
		endcase
	endtask

	task automatic program_regs(logic [31:0] g, logic [31:0] lim, bit stray);
		pose_if.valid <= 1'b0;
		while (cmd_expected.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		write_reg(gtg_pkg::REG_GAIN, g);
		write_reg(gtg_pkg::REG_SPEED_LIMIT, lim);
		if (stray) begin
			write_reg(REG_SPARE, $urandom);
			write_reg(REG_LAST, $urandom);
		end
		cfg_if.valid <= 1'b0;
		settings_count++;
	endtask

	task automatic flag_mismatch(string what, longint want, longint got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch in %s at command %0d: expected %0d, got %0d",
				what, cmd_count, want, got);
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			cmd_if.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 16);
			cmd_if.ready <= 1'b0;
		end else begin
			cmd_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : cmd_check
		cmd_t want;
		if (arst_n && cmd_if.valid && cmd_if.ready) begin
			if (cmd_expected.size() == 0) begin
				flag_mismatch("command with none pending", 0,
					longint'($signed(cmd_if.turn_rate)));
			end else begin
				want = cmd_expected.pop_front();
				if (cmd_if.turn_rate !== want.turn_rate)
					flag_mismatch("turn_rate", longint'($signed(want.turn_rate)),
						longint'($signed(cmd_if.turn_rate)));
				if (cmd_if.forward_speed !== want.forward_speed)
					flag_mismatch("forward_speed", longint'({32'd0, want.forward_speed}),
						longint'({32'd0, cmd_if.forward_speed}));
			end
			cmd_count++;
		end
	end

	initial begin : stimulus
		goal_row_t rows [$];
		cmd_t want;
		pose_t p;
		int ph, n, directed_n;
		clk = 1'b0;
		arst_n = 1'b0;
		idle_on = 1'b1;
		stall_left = 0;
		mismatch_count = 0;
		cmd_count = 0;
		settings_count = 1;
		gain_q88 = gtg_pkg::GAIN_RST;
		limit_q16 = gtg_pkg::SPEED_RST;
		pose_if.valid = 1'b0;
		pose_if.cur_x = '0;
		pose_if.cur_y = '0;
		pose_if.cur_heading = '0;
		pose_if.goal_x = '0;
		pose_if.goal_y = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		cmd_if.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = {rows, goal_row(0, 0, 0, 0, 0, 1, 0, 1, 0)};
		rows = {rows, goal_row(C_MAX, C_MAX, 4096, C_MAX, C_MAX, 1, -4096, 1, 0)};
		rows = {rows, goal_row(C_MIN, C_MIN, -4096, C_MIN, C_MIN, 1, 4096, 1, 0)};
		rows = {rows, goal_row(C_MIN, C_MIN, 0, C_MAX, C_MAX, 0, 0, 1, 65536)};
		rows = {rows, goal_row(C_MAX, C_MAX, 0, C_MIN, C_MIN, 0, 0, 1, 65536)};
		rows = {rows, goal_row(C_MIN, C_MAX, 0, C_MAX, C_MIN, 0, 0, 1, 65536)};
		rows = {rows, goal_row(C_MAX, 0, 0, C_MIN, 0, 0, 0, 1, 65536)};
		rows = {rows, goal_row(0, 0, 0, -65536, 0, 0, 0, 1, 65536)};
		rows = {rows, goal_row(0, 0, 0, -65536, 1, 0, 0, 0, 0)};
		rows = {rows, goal_row(0, 0, 0, -65536, -1, 0, 0, 0, 0)};
		rows = {rows, goal_row(0, 0, 0, 0, 65536, 0, 0, 1, 65536)};
		rows = {rows, goal_row(0, 0, 0, 0, -65536, 0, 0, 1, 65536)};
		rows = {rows, goal_row(0, 0, 0, 65536, 0, 0, 0, 1, 65536)};
		rows = {rows, goal_row(0, 0, 0, 32'h3000, 32'h4000, 0, 0, 1, 32'h5000)};
		rows = {rows, goal_row(0, 0, 0, 32'h30000, 32'h40000, 0, 0, 1, 65536)};
		rows = {rows, goal_row(5, 7, 32767, 5, 7, 0, 0, 1, 0)};
		rows = {rows, goal_row(5, 7, -32768, 5, 7, 0, 0, 1, 0)};
		rows = {rows, goal_row(0, 0, -32768, -65536, 1, 0, 0, 0, 0)};
		rows = {rows, goal_row(0, 0, 32767, -65536, -1, 0, 0, 0, 0)};
		rows = {rows, goal_row(0, 0, 12868, 0, 0, 0, 0, 1, 0)};
		rows = {rows, goal_row(0, 0, -12868, 0, 0, 0, 0, 1, 0)};
		rows = {rows, goal_row(-1, -1, 1, 0, 0, 0, 0, 0, 0)};
		rows = {rows, goal_row(0, 0, -1, 1, 0, 0, 0, 0, 0)};
		directed_n = rows.size();

		foreach (rows[k]) begin
			want = predict_cmd(rows[k].pose, gain_q88, limit_q16);
			if (rows[k].fixed_turn) want.turn_rate = rows[k].cmd.turn_rate;
			if (rows[k].fixed_speed) want.forward_speed = rows[k].cmd.forward_speed;
			send_pose(rows[k].pose, want);
		end

		for (ph = 0; ph < CONFIG_PHASES; ph++) begin
			case (ph)
				0: program_regs(32'h0000_0000, 32'h0000_0000, 1'b1);
				1: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
				2: program_regs(32'h1234_0100, 32'hFFFF_FFFF, 1'b1);
				3: program_regs($urandom, $urandom, 1'b0);
				4: program_regs(32'd1, 32'd1, 1'b0);
				5: program_regs($urandom, $urandom >> $urandom_range(0, 31), 1'b1);
				6: program_regs($urandom, 32'hFFFF_FFFF, 1'b0);
				default: program_regs($urandom, $urandom >> $urandom_range(0, 31), 1'b0);
			endcase
			if (ph == CONFIG_PHASES - 1) idle_on = 1'b0;
			for (n = 0; n < POSES_PER_PHASE; n++) begin
				p = rand_pose();
				send_pose(p, predict_cmd(p, gain_q88, limit_q16));
			end
		end
		pose_if.valid <= 1'b0;

		while (cmd_expected.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		$display("%0d directed and %0d random poses over %0d register settings",
			directed_n, CONFIG_PHASES * POSES_PER_PHASE, settings_count);
		$display("%0d commands checked under random input gaps and output stalls",
			cmd_count);
		if (mismatch_count == 0 && cmd_expected.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("timeout with %0d commands outstanding", cmd_expected.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
